/* src/ygfb_pkg.sv */
// Package for the Yee-grid magnetic field update unit.
// Holds field and register widths, register and mode codes, and the request and result structs.
// No dependencies.
`default_nettype none

package ygfb_pkg;

	localparam int FIELD_BITS     = 32;
	localparam int COEF_BITS      = 32;
	localparam int FRAC_BITS      = 30;
	localparam int GEO_BITS       = 7;
	localparam int MODE_BITS      = 2;
	localparam int MASK_BITS      = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [GEO_BITS-1:0] GEO_RESET = GEO_BITS'(64);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_RK_MODE    = 3'd0,
		REG_COEF_X     = 3'd1,
		REG_COEF_Y     = 3'd2,
		REG_COEF_Z     = 3'd3,
		REG_ROW_LENGTH = 3'd4,
		REG_PLANE_ROWS = 3'd5
	} cfg_reg_t;

	typedef enum logic [MODE_BITS-1:0] {
		RK_FULL   = 2'd0,
		RK_HALF   = 2'd1,
		RK_STAGE2 = 2'd2,
		RK_NONE   = 2'd3
	} rk_mode_t;

	typedef struct packed {
		logic                          first_cell;
		logic signed [FIELD_BITS-1:0]  ex;
		logic signed [FIELD_BITS-1:0]  ey;
		logic signed [FIELD_BITS-1:0]  ez;
		logic signed [FIELD_BITS-1:0]  bx;
		logic signed [FIELD_BITS-1:0]  by;
		logic signed [FIELD_BITS-1:0]  bz;
		logic        [MASK_BITS-1:0]   solve_mask;
	} cell_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0]  new_bx;
		logic signed [FIELD_BITS-1:0]  new_by;
		logic signed [FIELD_BITS-1:0]  new_bz;
		logic        [MASK_BITS-1:0]   written_mask;
	} result_t;

endpackage

`default_nettype wire

/* src/yee_grid_faraday_b_update_unit.sv */
// Top level of the Yee-grid magnetic field (Faraday) update unit.
// Plane-deep E store, three-stage curl pipeline and result register.
// Depends on ygfb_pkg.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------
//   cell     | cell_valid / cell_stall    | cell_req (cell_t)
//   result   | result_valid / result_stall| result (result_t)
//   config   | cfg_write                  | cfg_index, cfg_data
//
// One cell per clock unless result_stall backs up the pipeline.
// The E store has two registered read ports (row above, plane behind) and one
// write port; the cell to the left comes from a register of the last request.
// Reset clears counters, valids and config registers; the store needs no clearing pass.
// A stalled result holds its register; earlier stages keep filling until full.
`default_nettype none

module yee_grid_faraday_b_update_unit
	import ygfb_pkg::*;
#(
	parameter int MAX_ROW_CELLS  = 64,
	parameter int MAX_PLANE_ROWS = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cell_valid,
	output      logic                      cell_stall,
	input  wire cell_t                     cell_req,
	output      logic                      result_valid,
	input  wire logic                      result_stall,
	output      result_t                   result,
	input  wire logic                      cfg_write,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CW          = $clog2(MAX_ROW_CELLS);
	localparam int RW          = $clog2(MAX_PLANE_ROWS);
	localparam int AW          = CW + RW;
	localparam int STORE_DEPTH = 1 << AW;
	localparam int LW          = (CW + 1 > GEO_BITS) ? CW + 1 : GEO_BITS;
	localparam int PLW         = (RW + 1 > GEO_BITS) ? RW + 1 : GEO_BITS;
	localparam int F           = FIELD_BITS;
	localparam int PW          = F + COEF_BITS + 2;
	localparam int SUMW        = PW + 1;
	localparam int DW          = SUMW - FRAC_BITS;
	localparam int SW          = DW + 1;

	localparam logic signed [SUMW-1:0] RND_FULL = SUMW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUMW-1:0] RND_HALF = SUMW'(1) <<< FRAC_BITS;
	localparam logic signed [SW-1:0]   SAT_HI   = {{(SW-F+1){1'b0}}, {(F-1){1'b1}}};
	localparam logic signed [SW-1:0]   SAT_LO   = {{(SW-F+1){1'b1}}, {(F-1){1'b0}}};

	// configuration
	rk_mode_t              rk_mode_q;
	logic [COEF_BITS-1:0]  coef_x_q, coef_y_q, coef_z_q;
	logic [GEO_BITS-1:0]   row_length_q, plane_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rk_mode_q    <= RK_FULL;
			coef_x_q     <= '0;
			coef_y_q     <= '0;
			coef_z_q     <= '0;
			row_length_q <= GEO_RESET;
			plane_rows_q <= GEO_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_RK_MODE:    rk_mode_q    <= rk_mode_t'(cfg_data[MODE_BITS-1:0]);
				REG_COEF_X:     coef_x_q     <= cfg_data[COEF_BITS-1:0];
				REG_COEF_Y:     coef_y_q     <= cfg_data[COEF_BITS-1:0];
				REG_COEF_Z:     coef_z_q     <= cfg_data[COEF_BITS-1:0];
				REG_ROW_LENGTH: row_length_q <= cfg_data[GEO_BITS-1:0];
				REG_PLANE_ROWS: plane_rows_q <= cfg_data[GEO_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic valid_s1, valid_s2, valid_s3;
	logic ld_s1, ld_s2, ld_s3, ld_s4;
	logic accept;

	assign ld_s4      = !result_valid || !result_stall;
	assign ld_s3      = !valid_s3 || ld_s4;
	assign ld_s2      = !valid_s2 || ld_s3;
	assign ld_s1      = !valid_s1 || ld_s2;
	assign cell_stall = !ld_s1;
	assign accept     = cell_valid && ld_s1;

	// position counters
	logic [CW-1:0] col_q, col_cur;
	logic [RW-1:0] row_q, row_cur;
	logic          first_plane_q, first_plane_cur;
	logic [LW-1:0] row_len_eff;
	logic [PLW-1:0] plane_rows_eff;
	logic          col_wrap, row_wrap;

	always_comb begin
		if (row_length_q == '0)
			row_len_eff = LW'(1);
		else if (LW'(row_length_q) > LW'(MAX_ROW_CELLS))
			row_len_eff = LW'(MAX_ROW_CELLS);
		else
			row_len_eff = LW'(row_length_q);
		if (plane_rows_q == '0)
			plane_rows_eff = PLW'(1);
		else if (PLW'(plane_rows_q) > PLW'(MAX_PLANE_ROWS))
			plane_rows_eff = PLW'(MAX_PLANE_ROWS);
		else
			plane_rows_eff = PLW'(plane_rows_q);
		col_cur         = cell_req.first_cell ? '0 : col_q;
		row_cur         = cell_req.first_cell ? '0 : row_q;
		first_plane_cur = cell_req.first_cell || first_plane_q;
		col_wrap        = (LW'(col_cur) + LW'(1)) >= row_len_eff;
		row_wrap        = (PLW'(row_cur) + PLW'(1)) >= plane_rows_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			first_plane_q <= 1'b1;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q         <= '0;
					first_plane_q <= 1'b0;
				end else begin
					row_q         <= row_cur + RW'(1);
					first_plane_q <= first_plane_cur;
				end
			end else begin
				col_q         <= col_cur + CW'(1);
				row_q         <= row_cur;
				first_plane_q <= first_plane_cur;
			end
		end
	end

	// E plane store
	logic [3*F-1:0] store_mem [STORE_DEPTH];
	logic [AW-1:0]  wr_addr, up_addr;
	logic [3*F-1:0] e_in, e_last_q;
	logic [3*F-1:0] ej_s1, ek_s1;

	assign e_in    = {cell_req.ez, cell_req.ey, cell_req.ex};
	assign wr_addr = {row_cur, col_cur};
	assign up_addr = {row_cur - RW'(1), col_cur};

	always_ff @(posedge clk) begin
		if (accept)
			store_mem[wr_addr] <= e_in;
		if (ld_s1) begin
			ej_s1 <= store_mem[up_addr];
			ek_s1 <= store_mem[wr_addr];
		end
	end

	// stage 1: operands
	logic [3*F-1:0]          e_s1, ei_s1;
	logic [3*F-1:0]          b_s1;
	logic [MASK_BITS-1:0]    mask_s1;
	logic                    has_i_s1, has_j_s1, has_k_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			e_last_q <= e_in;
		end
		if (ld_s1) begin
			e_s1     <= e_in;
			ei_s1    <= e_last_q;
			b_s1     <= {cell_req.bz, cell_req.by, cell_req.bx};
			mask_s1  <= cell_req.solve_mask;
			has_i_s1 <= col_cur != '0;
			has_j_s1 <= row_cur != '0;
			has_k_s1 <= !first_plane_cur;
		end
	end

	// stage 2: differences and products
	logic signed [F:0]       diff [6];
	logic [COEF_BITS-1:0]    cf [6];
	logic signed [PW-1:0]    p_s2 [6];
	logic [3*F-1:0]          b_s2;
	logic [MASK_BITS-1:0]    wmask_s1, wmask_s2;

	function automatic logic signed [F:0] fsub(logic [F-1:0] a, logic [F-1:0] b);
		return (F+1)'($signed(a)) - (F+1)'($signed(b));
	endfunction

	always_comb begin
		diff[0] = fsub(ek_s1[F +: F],   e_s1[F +: F]);
		cf[0]   = coef_z_q;
		diff[1] = fsub(e_s1[2*F +: F],  ej_s1[2*F +: F]);
		cf[1]   = coef_y_q;
		diff[2] = fsub(ei_s1[2*F +: F], e_s1[2*F +: F]);
		cf[2]   = coef_x_q;
		diff[3] = fsub(e_s1[0 +: F],    ek_s1[0 +: F]);
		cf[3]   = coef_z_q;
		diff[4] = fsub(ej_s1[0 +: F],   e_s1[0 +: F]);
		cf[4]   = coef_y_q;
		diff[5] = fsub(e_s1[F +: F],    ei_s1[F +: F]);
		cf[5]   = coef_x_q;
		wmask_s1[0] = mask_s1[0] && has_j_s1 && has_k_s1 && (rk_mode_q != RK_NONE);
		wmask_s1[1] = mask_s1[1] && has_k_s1 && has_i_s1 && (rk_mode_q != RK_NONE);
		wmask_s1[2] = mask_s1[2] && has_i_s1 && has_j_s1 && (rk_mode_q != RK_NONE);
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			for (int n = 0; n < 6; n++)
				p_s2[n] <= diff[n] * $signed({1'b0, cf[n]});
			b_s2     <= b_s1;
			wmask_s2 <= wmask_s1;
		end
	end

	// stage 3: rounded increment
	logic signed [SUMW-1:0]  sum [3];
	logic signed [DW-1:0]    delta [3];
	logic signed [DW-1:0]    delta_s3 [3];
	logic [3*F-1:0]          b_s3;
	logic [MASK_BITS-1:0]    wmask_s3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = SUMW'(p_s2[2*c]) + SUMW'(p_s2[2*c+1])
				+ ((rk_mode_q == RK_HALF) ? RND_HALF : RND_FULL);
			delta[c] = (rk_mode_q == RK_HALF) ? DW'(sum[c] >>> (FRAC_BITS + 1))
				: DW'(sum[c] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			for (int c = 0; c < 3; c++)
				delta_s3[c] <= delta[c];
			b_s3     <= b_s2;
			wmask_s3 <= wmask_s2;
		end
	end

	// stage 4: add, saturate, select
	logic signed [SW-1:0]  upd [3];
	logic signed [F-1:0]   nb [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			upd[c] = SW'($signed(b_s3[c*F +: F])) + SW'(delta_s3[c]);
			if (!wmask_s3[c])
				nb[c] = $signed(b_s3[c*F +: F]);
			else if (upd[c] > SAT_HI)
				nb[c] = F'(SAT_HI);
			else if (upd[c] < SAT_LO)
				nb[c] = F'(SAT_LO);
			else
				nb[c] = F'(upd[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4 && valid_s3) begin
			result.new_bx       <= nb[0];
			result.new_by       <= nb[1];
			result.new_bz       <= nb[2];
			result.written_mask <= wmask_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (ld_s1) valid_s1 <= accept;
			if (ld_s2) valid_s2 <= valid_s1;
			if (ld_s3) valid_s3 <= valid_s2;
			if (ld_s4) result_valid <= valid_s3;
		end
	end

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request did not enter stage 1");

	a_mode_none_writes_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && rk_mode_q == RK_NONE) |-> (wmask_s2 == '0))
		else $error("component marked written in undefined mode");

	a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && result_valid && result_stall) |-> cell_stall)
		else $error("full pipeline took a request");

	a_first_cell_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cell_req.first_cell) |=>
			((col_q == '0 || col_q == CW'(1)) && (row_q == '0 || row_q == RW'(1))))
		else $error("counters did not restart on first cell");
`endif

endmodule

`default_nettype wire

/* dv/tb_yee_grid_faraday_b_update_unit.sv */
// Self-checking testbench for yee_grid_faraday_b_update_unit: streams boxes of grid cells
// under several register settings and checks each updated B against an in-bench predictor.
// Depends on ygfb_pkg and the unit's top level.

module tb_yee_grid_faraday_b_update_unit
	import ygfb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_CELLS      = 64;
	localparam int PLANE_ROWS_MAX = 64;
	localparam int STORE_CELLS    = ROW_CELLS * PLANE_ROWS_MAX;
	localparam int IDX_BITS       = $clog2(STORE_CELLS);
	localparam int ACC_BITS       = 2 * FIELD_BITS + 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 11;

	localparam logic signed [FIELD_BITS-1:0] F_MAX = {1'b0, {(FIELD_BITS-1){1'b1}}};
	localparam logic signed [FIELD_BITS-1:0] F_MIN = {1'b1, {(FIELD_BITS-1){1'b0}}};
	localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(F_MAX);
	localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] x;
		logic signed [FIELD_BITS-1:0] y;
		logic signed [FIELD_BITS-1:0] z;
	} efield_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cell_valid   = 1'b0;
	logic                      cell_stall;
	cell_t                     cell_req     = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	result_t                   result;
	logic                      cfg_write    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

	yee_grid_faraday_b_update_unit #(
		.MAX_ROW_CELLS (ROW_CELLS),
		.MAX_PLANE_ROWS(PLANE_ROWS_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_valid  (cell_valid),
		.cell_stall  (cell_stall),
		.cell_req    (cell_req),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// predictor state
	efield_t               e_plane [0:STORE_CELLS-1];
	int unsigned           col_pos     = 0;
	int unsigned           row_pos     = 0;
	bit                    first_plane = 1'b1;
	rk_mode_t              mode_reg    = RK_FULL;
	logic [COEF_BITS-1:0]  coef_x_reg  = '0;
	logic [COEF_BITS-1:0]  coef_y_reg  = '0;
	logic [COEF_BITS-1:0]  coef_z_reg  = '0;
	logic [GEO_BITS-1:0]   row_len_reg = GEO_RESET;
	logic [GEO_BITS-1:0]   rows_reg    = GEO_RESET;

	cell_t   cells_to_send [$];
	result_t predicted_b [$];
	bit      cell_taken   = 1'b0;
	bit      steady       = 1'b0;
	int      send_gap     = 0;
	int      stall_left   = 0;
	int      quiet_cycles = 0;
	int      mismatches   = 0;

	int unsigned plan_rl    [PHASES] = '{2, 1, 0, 4, 64, 2, 127, 3, 7, 1, 5};
	int unsigned plan_rows  [PHASES] = '{3, 1, 0, 3, 2, 64, 100, 5, 1, 7, 4};
	int unsigned plan_cells [PHASES] = '{80, 60, 40, 100, 270, 260, 140, 100, 60, 60, 80};

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned clamp_geo(int unsigned v, int unsigned top);
		return (v == 0) ? 1 : ((v > top) ? top : v);
	endfunction

	function automatic logic signed [FIELD_BITS-1:0] faraday_sum(
		logic signed [FIELD_BITS-1:0] b,
		logic signed [FIELD_BITS:0]   d1,
		logic [COEF_BITS-1:0]         c1,
		logic signed [FIELD_BITS:0]   d2,
		logic [COEF_BITS-1:0]         c2,
		int unsigned                  sh
	);
		logic signed [ACC_BITS-1:0] a1, a2, m1, m2, acc, bb;
		a1 = ACC_BITS'(d1);
		a2 = ACC_BITS'(d2);
		m1 = {{(ACC_BITS-COEF_BITS){1'b0}}, c1};
		m2 = {{(ACC_BITS-COEF_BITS){1'b0}}, c2};
		bb = ACC_BITS'(b);
		acc = a1 * m1 + a2 * m2;
		acc = acc + (ACC_BITS'(1) << (sh - 1));
		acc = acc >>> sh;
		acc = acc + bb;
		if (acc > SAT_HI)
			return F_MAX;
		if (acc < SAT_LO)
			return F_MIN;
		return acc[FIELD_BITS-1:0];
	endfunction

	function automatic void predict_b_update(cell_t c);
		efield_t                    e, ei, ej, ek;
		result_t                    r;
		int unsigned                rl, pr, sh;
		logic [IDX_BITS-1:0]        idx;
		bit                         has_i, has_j, has_k;
		logic signed [FIELD_BITS:0] d1, d2;
		rl = clamp_geo(32'(row_len_reg), ROW_CELLS);
		pr = clamp_geo(32'(rows_reg), PLANE_ROWS_MAX);
		if (c.first_cell) begin
			col_pos = 0;
			row_pos = 0;
			first_plane = 1'b1;
		end
		e.x = c.ex;
		e.y = c.ey;
		e.z = c.ez;
		r.new_bx = c.bx;
		r.new_by = c.by;
		r.new_bz = c.bz;
		r.written_mask = '0;
		idx = IDX_BITS'(row_pos * ROW_CELLS + col_pos);
		has_i = col_pos > 0;
		has_j = row_pos > 0;
		has_k = !first_plane;
		ei = '0;
		ej = '0;
		ek = '0;
		if (has_i) ei = e_plane[idx - IDX_BITS'(1)];
		if (has_j) ej = e_plane[idx - IDX_BITS'(ROW_CELLS)];
		if (has_k) ek = e_plane[idx];
		if (mode_reg != RK_NONE) begin
			sh = (mode_reg == RK_HALF) ? FRAC_BITS + 1 : FRAC_BITS;
			if (c.solve_mask[0] && has_j && has_k) begin
				d1 = ek.y - e.y;
				d2 = e.z - ej.z;
				r.new_bx = faraday_sum(c.bx, d1, coef_z_reg, d2, coef_y_reg, sh);
				r.written_mask[0] = 1'b1;
			end
			if (c.solve_mask[1] && has_k && has_i) begin
				d1 = ei.z - e.z;
				d2 = e.x - ek.x;
				r.new_by = faraday_sum(c.by, d1, coef_x_reg, d2, coef_z_reg, sh);
				r.written_mask[1] = 1'b1;
			end
			if (c.solve_mask[2] && has_i && has_j) begin
				d1 = ej.x - e.x;
				d2 = e.y - ei.y;
				r.new_bz = faraday_sum(c.bz, d1, coef_y_reg, d2, coef_x_reg, sh);
				r.written_mask[2] = 1'b1;
			end
		end
		e_plane[idx] = e;
		if (col_pos + 1 >= rl) begin
			col_pos = 0;
			if (row_pos + 1 >= pr) begin
				row_pos = 0;
				first_plane = 1'b0;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		predicted_b = {predicted_b, r};
	endfunction

	task automatic check_field(string what, logic [FIELD_BITS-1:0] want, logic [FIELD_BITS-1:0] got);
		if (want !== got) begin
			$display("%0t %s: expected %h actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : track
		result_t want;
		bit      result_taken;
		cell_taken = cell_valid && !cell_stall;
		result_taken = result_valid && !result_stall;
		if (cell_taken)
			predict_b_update(cell_req);
		if (result_taken) begin
			if (predicted_b.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $time, result);
				mismatches++;
			end else begin
				want = predicted_b.pop_front();
				check_field("new_bx", want.new_bx, result.new_bx);
				check_field("new_by", want.new_by, result.new_by);
				check_field("new_bz", want.new_bz, result.new_bz);
				check_field("written_mask", FIELD_BITS'(want.written_mask),
					FIELD_BITS'(result.written_mask));
			end
		end
		if (cell_taken || result_taken) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no request moved for %0d cycles", $time, quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	always @(negedge clk) begin : drive_cells
		logic  next_valid;
		cell_t next_cell;
		next_valid = cell_valid;
		next_cell = cell_req;
		if (!cell_valid || cell_taken) begin
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (!steady && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 16) - 1;
			end else if (cells_to_send.size() > 0) begin
				next_valid = 1'b1;
				next_cell = cells_to_send.pop_front();
			end
		end
		cell_valid <= next_valid;
		cell_req <= next_cell;
	end

	always @(negedge clk) begin
		if (steady) begin
			stall_left = 0;
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic logic signed [FIELD_BITS-1:0] pick_field();
		case ($urandom_range(0, 5))
			0: return FIELD_BITS'($urandom_range(0, 2000)) - FIELD_BITS'(1000);
			1: return F_MAX - FIELD_BITS'($urandom_range(0, 15));
			2: return F_MIN + FIELD_BITS'($urandom_range(0, 15));
			3: return $urandom_range(0, 1) ? FIELD_BITS'(0) : FIELD_BITS'(-1);
			default: return FIELD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [COEF_BITS-1:0] pick_coef();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return COEF_BITS'(1) << FRAC_BITS;
			default: return COEF_BITS'($urandom);
		endcase
	endfunction

	function automatic cell_t random_cell(bit first);
		cell_t c;
		c.first_cell = first;
		c.ex = pick_field();
		c.ey = pick_field();
		c.ez = pick_field();
		c.bx = pick_field();
		c.by = pick_field();
		c.bz = pick_field();
		c.solve_mask = ($urandom_range(0, 2) == 0) ? MASK_BITS'($urandom_range(0, 7)) : '1;
		return c;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			REG_RK_MODE:    mode_reg = rk_mode_t'(v[MODE_BITS-1:0]);
			REG_COEF_X:     coef_x_reg = v[COEF_BITS-1:0];
			REG_COEF_Y:     coef_y_reg = v[COEF_BITS-1:0];
			REG_COEF_Z:     coef_z_reg = v[COEF_BITS-1:0];
			REG_ROW_LENGTH: row_len_reg = v[GEO_BITS-1:0];
			REG_PLANE_ROWS: rows_reg = v[GEO_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(rk_mode_t m, logic [COEF_BITS-1:0] cx, logic [COEF_BITS-1:0] cy,
		logic [COEF_BITS-1:0] cz, int unsigned rl, int unsigned pr);
		write_reg(REG_RK_MODE, CFG_DATA_BITS'(m));
		write_reg(REG_COEF_X, CFG_DATA_BITS'(cx));
		write_reg(REG_COEF_Y, CFG_DATA_BITS'(cy));
		write_reg(REG_COEF_Z, CFG_DATA_BITS'(cz));
		write_reg(REG_ROW_LENGTH, CFG_DATA_BITS'(rl));
		write_reg(REG_PLANE_ROWS, CFG_DATA_BITS'(pr));
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (cells_to_send.size() != 0 || cell_valid || predicted_b.size() != 0);
	endtask

	initial begin : stimulus
		cell_t       c;
		int unsigned rl, pr, box_len, queued, k;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// saturating extremes on a 2x2 box, then mask sweep over three planes
		program_regs(RK_FULL, '1, '1, '1, 2, 2);
		for (int n = 0; n < 8; n++) begin
			c.first_cell = (n == 0);
			c.ex = n[0] ? F_MIN : F_MAX;
			c.ey = n[1] ? F_MAX : F_MIN;
			c.ez = n[2] ? F_MIN : F_MAX;
			c.bx = n[0] ? F_MIN : F_MAX;
			c.by = n[1] ? F_MIN : F_MAX;
			c.bz = n[2] ? F_MAX : F_MIN;
			c.solve_mask = '1;
			cells_to_send = {cells_to_send, c};
		end
		for (int n = 0; n < 12; n++) begin
			c = random_cell(n == 0);
			c.solve_mask = MASK_BITS'(n);
			cells_to_send = {cells_to_send, c};
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p == PHASES - 1)
				steady = 1'b1;
			program_regs(rk_mode_t'(MODE_BITS'(p % 4)), pick_coef(), pick_coef(), pick_coef(),
				plan_rl[p], plan_rows[p]);
			rl = clamp_geo(plan_rl[p], ROW_CELLS);
			pr = clamp_geo(plan_rows[p], PLANE_ROWS_MAX);
			queued = 0;
			while (queued < plan_cells[p]) begin
				box_len = rl * pr * $urandom_range(1, 3);
				for (k = 0; k < box_len && queued < plan_cells[p]; k++) begin
					c = random_cell(k == 0 || $urandom_range(0, 39) == 0);
					cells_to_send = {cells_to_send, c};
					queued++;
				end
			end
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (predicted_b.size() != 0) begin
			$display("%0t results missing: expected %0d more actual 0", $time, predicted_b.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
